@@ hw/rtl/page_frame_replacement_core_defines.svh @@
// Assertion macros for the page frame replacement core.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef PAGE_FRAME_REPLACEMENT_CORE_DEFINES_SVH
`define PAGE_FRAME_REPLACEMENT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfr assertion failed");

`endif

@@ hw/rtl/pfr_pkg.sv @@
// Shared types and constants of the page frame replacement core.
// No dependencies; used by the controller, the datapath and the top level.
package pfr_pkg;

    localparam int NFRAMES_DEF = 64;
    localparam int NPAGES_DEF  = 256;

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    localparam logic [1:0] POL_RAND  = 2'd0;
    localparam logic [1:0] POL_CLOCK = 2'd1;
    localparam logic [1:0] POL_FIFO  = 2'd2;

    localparam logic REQ_FAULT = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [2:0] ST_FILL    = 3'd0;
    localparam logic [2:0] ST_CLEAN   = 3'd1;
    localparam logic [2:0] ST_DIRTY   = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_MARK    = 3'd4;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_FRAMES = 2'd1;
    localparam logic [1:0] REG_SEED   = 2'd2;

    typedef struct packed {
        logic clr;
        logic accept;
        logic idx_take;
        logic look;
        logic rand_take;
        logic ck_rd;
        logic ck_chk;
        logic evict;
        logic load;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       mod_busy;
        logic       req_type;
        logic       hit;
        logic       fill_ok;
        logic [1:0] policy;
        logic       ref_bit;
        logic       out_free;
    } t_sts;

endpackage

@@ hw/rtl/page_frame_replacement_core.sv @@
// Page frame replacement core: a beat passes PMOD, MAPRD, LOOK; a mark or hit goes to FIN,
// a free-frame fill via LOAD, an oldest-loaded eviction via EVRD, EVICT and LOAD; a random
// eviction first waits in RMOD for the 32-step remainder unit, a clock eviction runs CKRD
// and CKCHK for each frame the hand visits. One beat is in work at a time; the next is
// accepted once the result is registered, and waits in FIN while that result is not taken.
// After reset the page map is cleared first. Depends on pfr_pkg, pfr_ctrl, pfr_dp.
module page_frame_replacement_core #(
    parameter int NFRAMES = pfr_pkg::NFRAMES_DEF,
    parameter int NPAGES  = pfr_pkg::NPAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_page,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_frame,
    output logic [7:0]  o_victim_page,
    output logic        o_writeback,
    output logic [31:0] o_fault_count,
    output logic [31:0] o_read_count,
    output logic [31:0] o_write_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfr_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [1:0]  r_policy;
    logic [6:0]  r_frames;
    logic [31:0] r_seed;
    logic        wr_en;
    logic        seed_wr;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign seed_wr = wr_en && (paddr[3:2] == REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_CLOCK;
            r_frames <= 7'd64;
            r_seed   <= 32'd1;
        end else if (wr_en) begin
            if (paddr[3:2] == REG_POLICY) r_policy <= pwdata[1:0];
            if (paddr[3:2] == REG_FRAMES) r_frames <= pwdata[6:0];
            if (paddr[3:2] == REG_SEED)   r_seed   <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_POLICY: prdata = 32'(r_policy);
            REG_FRAMES: prdata = 32'(r_frames);
            REG_SEED:   prdata = r_seed;
            default:    prdata = 32'd0;
        endcase
    end

    pfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfr_dp #(
        .NFRAMES (NFRAMES),
        .NPAGES  (NPAGES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_page        (i_page),
        .i_policy      (r_policy),
        .i_frames      (r_frames),
        .i_seed_wr     (seed_wr),
        .i_seed        (pwdata),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_frame       (o_frame),
        .o_victim_page (o_victim_page),
        .o_writeback   (o_writeback),
        .o_fault_count (o_fault_count),
        .o_read_count  (o_read_count),
        .o_write_count (o_write_count)
    );

endmodule

@@ hw/rtl/pfr_ctrl.sv @@
// Controller state machine of the page frame replacement core.
// Depends on pfr_pkg; drives the datapath through t_cmd and reads t_sts.
module pfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfr_pkg::t_sts i_sts,
    output pfr_pkg::t_cmd o_cmd
);
    import pfr_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_PMOD  = 12'b0000_0000_0100,
        S_MAPRD = 12'b0000_0000_1000,
        S_LOOK  = 12'b0000_0001_0000,
        S_RMOD  = 12'b0000_0010_0000,
        S_CKRD  = 12'b0000_0100_0000,
        S_CKCHK = 12'b0000_1000_0000,
        S_EVRD  = 12'b0001_0000_0000,
        S_EVICT = 12'b0010_0000_0000,
        S_LOAD  = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PMOD;
                end
            end
            S_PMOD: begin
                if (!i_sts.mod_busy) begin
                    o_cmd.idx_take = 1'b1;
                    n_state        = S_MAPRD;
                end
            end
            S_MAPRD: n_state = S_LOOK;
            S_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_sts.req_type == REQ_WRITE || i_sts.hit) n_state = S_FIN;
                else if (i_sts.fill_ok) n_state = S_LOAD;
                else if (i_sts.policy == POL_RAND) n_state = S_RMOD;
                else if (i_sts.policy == POL_FIFO) n_state = S_EVRD;
                else n_state = S_CKRD;
            end
            S_RMOD: begin
                if (!i_sts.mod_busy) begin
                    o_cmd.rand_take = 1'b1;
                    n_state         = S_EVRD;
                end
            end
            S_CKRD: begin
                o_cmd.ck_rd = 1'b1;
                n_state     = S_CKCHK;
            end
            S_CKCHK: begin
                o_cmd.ck_chk = 1'b1;
                n_state      = i_sts.ref_bit ? S_CKRD : S_EVRD;
            end
            S_EVRD: n_state = S_EVICT;
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

@@ hw/rtl/pfr_dp.sv @@
// Datapath of the page frame replacement core: frame and page memories,
// serial remainder unit, LFSR, counters and output register. Uses pfr_pkg.
module pfr_dp #(
    parameter int NFRAMES = pfr_pkg::NFRAMES_DEF,
    parameter int NPAGES  = pfr_pkg::NPAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pfr_pkg::t_cmd i_cmd,
    output pfr_pkg::t_sts o_sts,
    input  logic          i_req_type,
    input  logic [7:0]    i_page,
    input  logic [1:0]    i_policy,
    input  logic [6:0]    i_frames,
    input  logic          i_seed_wr,
    input  logic [31:0]   i_seed,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [2:0]    o_status,
    output logic [5:0]    o_frame,
    output logic [7:0]    o_victim_page,
    output logic          o_writeback,
    output logic [31:0]   o_fault_count,
    output logic [31:0]   o_read_count,
    output logic [31:0]   o_write_count
);
    import pfr_pkg::*;
    `include "page_frame_replacement_core_defines.svh"

    localparam int FW = (NFRAMES > 1) ? $clog2(NFRAMES) : 1;
    localparam int CW = $clog2(NFRAMES + 1);
    localparam int PW = (NPAGES > 1) ? $clog2(NPAGES) : 1;
    localparam int DW = CW + 1;
    localparam int OW = 8 + PW;
    localparam int unsigned RECIP = (65536 + NPAGES - 1) / NPAGES;

    logic [OW-1:0] mem_owner [NFRAMES];
    logic          mem_dirty [NFRAMES];
    logic          mem_ref   [NFRAMES];
    logic [FW:0]   mem_map   [NPAGES];

    logic          r_req;
    logic [7:0]    r_page;
    logic [PW-1:0] r_idx;
    logic [FW-1:0] r_frame;
    logic [FW-1:0] r_hand;
    logic [FW-1:0] r_fifo;
    logic [CW-1:0] r_filled;
    logic          r_is_fill;
    logic [2:0]    r_status;
    logic [7:0]    r_evicted;
    logic          r_wb;
    logic [31:0]   r_lfsr;
    logic [31:0]   r_faults;
    logic [31:0]   r_reads;
    logic [31:0]   r_writes;
    logic [PW-1:0] r_clr;
    logic [31:0]   r_mdiv;
    logic [DW-1:0] r_mrem;
    logic [DW-1:0] r_mdvs;
    logic [5:0]    r_mcnt;
    logic [OW-1:0] r_owner_rd;
    logic          r_dirty_rd;
    logic          r_ref_rd;
    logic [FW:0]   r_map_rd;

    logic [31:0]   frames32;
    logic [31:0]   n32;
    logic [CW-1:0] n;
    logic [FW-1:0] fifo_w;
    logic [FW-1:0] fifo_nx;
    logic [FW-1:0] hand_w;
    logic [FW-1:0] hand_nx;
    logic [CW-1:0] sum_f;
    logic [CW-1:0] sum_h;
    logic [31:0]   n_lfsr;
    logic [DW-1:0] m_t;
    logic [DW-1:0] m_nx;
    logic [24:0]   pq_prod;
    logic [7:0]    pq;
    logic [31:0]   idx_full;
    logic          hit;
    logic          fill_ok;
    logic          is_clock;
    logic [FW-1:0] rd_addr;
    logic [FW-1:0] map_frame;
    logic          d_we;
    logic [FW-1:0] d_addr;
    logic          d_data;
    logic          f_we;
    logic [FW-1:0] f_addr;
    logic          f_data;
    logic          m_we;
    logic [PW-1:0] m_addr;
    logic [FW:0]   m_data;

    always_comb begin
        frames32 = 32'(i_frames);
        if (frames32 == 32'd0) n32 = 32'd1;
        else if (frames32 > 32'(NFRAMES)) n32 = 32'(NFRAMES);
        else n32 = frames32;
        n = CW'(n32);

        fifo_w  = (CW'(r_fifo) >= n) ? '0 : r_fifo;
        sum_f   = CW'(fifo_w) + CW'(1);
        fifo_nx = (sum_f == n) ? '0 : FW'(sum_f);
        hand_w  = (CW'(r_hand) >= n) ? '0 : r_hand;
        sum_h   = CW'(r_hand) + CW'(1);
        hand_nx = (sum_h == n) ? '0 : FW'(sum_h);

        n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 32'd0);

        m_t  = {r_mrem[DW-2:0], r_mdiv[31]};
        m_nx = (m_t >= r_mdvs) ? (m_t - r_mdvs) : m_t;

        // The page index is the page modulo NPAGES, by reciprocal multiplication.
        pq_prod  = 25'(r_page) * 25'(RECIP);
        pq       = pq_prod[23:16];
        idx_full = 32'(r_page) - 32'(pq) * 32'(NPAGES);

        hit       = r_map_rd[FW];
        map_frame = r_map_rd[FW-1:0];
        fill_ok   = (r_filled < n);
        is_clock  = (i_policy == POL_CLOCK) || (i_policy == 2'd3);
        rd_addr   = i_cmd.ck_rd ? r_hand : r_frame;

        d_we   = (i_cmd.look && r_req == REQ_WRITE && hit) || i_cmd.load;
        d_addr = i_cmd.load ? r_frame : map_frame;
        d_data = !i_cmd.load;

        f_we   = (i_cmd.ck_chk && r_ref_rd) || (i_cmd.load && (is_clock || r_is_fill));
        f_addr = i_cmd.load ? r_frame : r_hand;
        f_data = i_cmd.load && is_clock;

        m_we   = i_cmd.clr || i_cmd.evict || i_cmd.load;
        priority if (i_cmd.clr) begin
            m_addr = r_clr;
            m_data = '0;
        end else if (i_cmd.evict) begin
            m_addr = r_owner_rd[PW-1:0];
            m_data = '0;
        end else begin
            m_addr = r_idx;
            m_data = {1'b1, r_frame};
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_we) mem_map[m_addr] <= m_data;
        r_map_rd <= mem_map[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) mem_owner[r_frame] <= {r_page, r_idx};
        r_owner_rd <= mem_owner[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) mem_dirty[d_addr] <= d_data;
        r_dirty_rd <= mem_dirty[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) mem_ref[f_addr] <= f_data;
        r_ref_rd <= mem_ref[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_mcnt      <= '0;
            r_filled    <= '0;
            r_hand      <= '0;
            r_fifo      <= '0;
            r_lfsr      <= 32'd1;
            r_faults    <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + PW'(1);
            if (i_seed_wr) r_lfsr <= (i_seed == 32'd0) ? 32'd1 : i_seed;

            if (i_cmd.accept) begin
                r_req  <= i_req_type;
                r_page <= i_page;
            end

            if (r_mcnt != 6'd0) begin
                r_mdiv <= {r_mdiv[30:0], 1'b0};
                r_mrem <= m_nx;
                r_mcnt <= r_mcnt - 6'd1;
            end

            if (i_cmd.idx_take) r_idx <= PW'(idx_full);

            if (i_cmd.look) begin
                r_evicted <= '0;
                r_wb      <= 1'b0;
                if (r_req == REQ_WRITE) begin
                    r_status <= ST_MARK;
                    r_frame  <= hit ? map_frame : '0;
                end else begin
                    r_faults <= r_faults + 32'd1;
                    if (hit) begin
                        r_status <= ST_PRESENT;
                        r_frame  <= map_frame;
                    end else if (fill_ok) begin
                        r_status  <= ST_FILL;
                        r_frame   <= FW'(r_filled);
                        r_filled  <= r_filled + CW'(1);
                        r_is_fill <= 1'b1;
                    end else begin
                        r_is_fill <= 1'b0;
                        if (i_policy == POL_RAND) begin
                            r_lfsr <= n_lfsr;
                            r_mdiv <= n_lfsr;
                            r_mdvs <= DW'(n);
                            r_mrem <= '0;
                            r_mcnt <= 6'd32;
                        end else if (i_policy == POL_FIFO) begin
                            r_frame <= fifo_w;
                            r_fifo  <= fifo_nx;
                        end else begin
                            r_hand <= hand_w;
                        end
                    end
                end
            end

            if (i_cmd.rand_take) r_frame <= FW'(r_mrem);

            if (i_cmd.ck_chk) begin
                r_hand <= hand_nx;
                if (!r_ref_rd) r_frame <= r_hand;
            end

            if (i_cmd.evict) begin
                r_evicted <= r_owner_rd[OW-1:PW];
                r_wb      <= r_dirty_rd;
                r_status  <= r_dirty_rd ? ST_DIRTY : ST_CLEAN;
                if (r_dirty_rd) r_writes <= r_writes + 32'd1;
            end

            if (i_cmd.load) r_reads <= r_reads + 32'd1;

            if (i_cmd.fin) begin
                o_out_valid   <= 1'b1;
                o_status      <= r_status;
                o_frame       <= 6'(r_frame);
                o_victim_page <= r_evicted;
                o_writeback   <= r_wb;
                o_fault_count <= r_faults;
                o_read_count  <= r_reads;
                o_write_count <= r_writes;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.clr_done = (32'(r_clr) == 32'(NPAGES - 1));
        o_sts.mod_busy = (r_mcnt != 6'd0);
        o_sts.req_type = r_req;
        o_sts.hit      = hit;
        o_sts.fill_ok  = fill_ok;
        o_sts.policy   = i_policy;
        o_sts.ref_bit  = r_ref_rd;
        o_sts.out_free = !o_out_valid || i_out_ready;
    end

    `PFR_ASSERT_IMP(a_fin_slot_free, i_cmd.fin, !o_out_valid || i_out_ready)
    `PFR_ASSERT_IMP(a_load_in_range, i_cmd.load, CW'(r_frame) < n)
    `PFR_ASSERT_IMP(a_evict_only_full, i_cmd.evict, r_filled >= n)
    `PFR_ASSERT_IMP(a_idx_in_range, i_cmd.idx_take, idx_full < 32'(NPAGES))
    `PFR_ASSERT_NXT(a_rand_starts_mod, i_cmd.look && r_req == REQ_FAULT && !hit && !fill_ok && i_policy == POL_RAND, r_mcnt == 6'd32)

endmodule
